### rtl/core/nec_ir_frame_transmitter_assert.svh
// Assertion macros for the NEC IR transmitter checker.
`ifndef NEC_IR_FRAME_TRANSMITTER_ASSERT_SVH
`define NEC_IR_FRAME_TRANSMITTER_ASSERT_SVH

// Property checked at every clock edge outside reset.
`define NECIRTX_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("necirtx: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define NECIRTX_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("necirtx: assertion failed");

`endif

### rtl/core/necirtx_pkg.sv
// Constants and codes for the NEC IR frame transmitter.
package necirtx_pkg;

  // Opcodes on the command channel
  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_SEND = 2'd1;
  localparam logic [1:0] OP_STOP = 2'd2;

  // Configuration register indexes
  localparam logic REG_UNIT_TICKS   = 1'b0;
  localparam logic REG_FRAME_PERIOD = 1'b1;

  localparam int unsigned CfgDataW = 20;
  localparam int unsigned UnitW    = 16;
  localparam int unsigned PeriodW  = 20;
  localparam int unsigned UnitsW   = 5;
  localparam int unsigned CodeW    = 32;

  localparam logic [UnitW-1:0]   UNIT_TICKS_RST   = 16'd562;
  localparam logic [PeriodW-1:0] FRAME_PERIOD_RST = 20'd108000;
  localparam logic [PeriodW-1:0] PERIOD_MAX       = 20'hFFFFF;

  // Envelope phases
  localparam logic [3:0] PH_IDLE     = 4'd0;
  localparam logic [3:0] PH_PRE_ON1  = 4'd1;
  localparam logic [3:0] PH_PRE_OFF  = 4'd2;
  localparam logic [3:0] PH_PRE_ON2  = 4'd3;
  localparam logic [3:0] PH_GAP      = 4'd4;
  localparam logic [3:0] PH_LEAD_ON  = 4'd5;
  localparam logic [3:0] PH_LEAD_OFF = 4'd6;
  localparam logic [3:0] PH_BIT_ON   = 4'd7;
  localparam logic [3:0] PH_BIT_OFF  = 4'd8;
  localparam logic [3:0] PH_STOP_ON  = 4'd9;
  localparam logic [3:0] PH_RPT_WAIT = 4'd10;
  localparam logic [3:0] PH_RPT_ON   = 4'd11;
  localparam logic [3:0] PH_RPT_OFF  = 4'd12;
  localparam logic [3:0] PH_RPT_END  = 4'd13;

  // Segment lengths in units
  localparam logic [UnitsW-1:0] U_1  = 5'd1;
  localparam logic [UnitsW-1:0] U_2  = 5'd2;
  localparam logic [UnitsW-1:0] U_3  = 5'd3;
  localparam logic [UnitsW-1:0] U_4  = 5'd4;
  localparam logic [UnitsW-1:0] U_8  = 5'd8;
  localparam logic [UnitsW-1:0] U_16 = 5'd16;

  function automatic logic carrier_of(logic [3:0] ph);
    return (ph == PH_PRE_ON1) || (ph == PH_PRE_ON2) || (ph == PH_LEAD_ON) ||
           (ph == PH_BIT_ON) || (ph == PH_STOP_ON) || (ph == PH_RPT_ON) ||
           (ph == PH_RPT_END);
  endfunction

endpackage

### rtl/core/necirtx_if.sv
// Command and envelope channel interfaces of the NEC IR transmitter.
interface necirtx_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] code;
  logic        repeat_wanted;

  modport source (output valid, output opcode, output code, output repeat_wanted,
                  input ready);
  modport sink (input valid, input opcode, input code, input repeat_wanted,
                output ready);
endinterface

interface necirtx_out_if;
  logic valid;
  logic ready;
  logic carrier_on;
  logic busy_res;
  logic repeating;

  modport source (output valid, output carrier_on, output busy_res, output repeating,
                  input ready);
  modport sink (input valid, input carrier_on, input busy_res, input repeating,
                output ready);
endinterface

### rtl/core/nec_ir_frame_transmitter.sv
// NEC IR frame transmitter: carrier on/off envelope paced by tick beats.
//
// in_i carries commands: a tick advances time by one tick, a send starts a
// frame (ignored while busy), a stop ends repeat frames. Every command beat
// yields exactly one beat on out_o with carrier_on, busy_res and repeating.
// For a tick the result is the level during that tick; for other commands it
// is the state after the command.
// The result beat is registered: it is in the output register on the edge
// after the command is taken. Commands are taken at one beat per cycle while
// the receiver keeps up; the state update sits before the output register.
// in_i.ready is high while the output register is empty or being drained, so
// a stalled receiver holds the result and backs up the command channel after
// one beat.
// cfg_we_i writes unit_ticks (index 0) or frame_period_ticks (index 1); write
// only while no result is outstanding.
// Reset clears the envelope state to idle and loads 562 ticks per unit and a
// 108000-tick frame period.
module nec_ir_frame_transmitter #(
  parameter int unsigned CODE_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  necirtx_in_if.sink                    in_i,
  necirtx_out_if.source                 out_o,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [necirtx_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import necirtx_pkg::*;

  localparam int unsigned BitsW = $clog2(CODE_BITS + 1);
  localparam logic [BitsW-1:0] BITS_INIT = BitsW'(CODE_BITS);

  logic [UnitW-1:0]     unit_ticks_q;
  logic [PeriodW-1:0]   frame_period_q;
  logic [3:0]           phase_q, phase_d;
  logic [CODE_BITS-1:0] shift_q, shift_d;
  logic [BitsW-1:0]     bits_left_q, bits_left_d;
  logic [UnitW-1:0]     tick_cnt_q, tick_cnt_d;
  logic [UnitsW-1:0]    units_q, units_d;
  logic [PeriodW-1:0]   period_q, period_d;
  logic                 repeat_q, repeat_d;

  logic                 out_valid_q;
  logic                 carrier_q, busy_q, repeating_q;
  logic [3:0]           res_phase;
  logic                 in_fire;
  logic                 unit_end;
  logic [PeriodW-1:0]   per_inc;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;
  assign unit_end   = ({1'b0, tick_cnt_q} + 17'd1) >= {1'b0, unit_ticks_q};
  assign per_inc    = (phase_q >= PH_GAP && period_q != PERIOD_MAX) ?
                      period_q + 20'd1 : period_q;

  always_comb begin
    phase_d     = phase_q;
    shift_d     = shift_q;
    bits_left_d = bits_left_q;
    tick_cnt_d  = tick_cnt_q;
    units_d     = units_q;
    period_d    = period_q;
    repeat_d    = repeat_q;
    if (in_fire) begin
      case (in_i.opcode)
        OP_TICK: begin
          if (phase_q != PH_IDLE) begin
            period_d = per_inc;
            if (phase_q == PH_RPT_WAIT) begin
              if (per_inc >= frame_period_q) begin
                period_d   = '0;
                phase_d    = PH_RPT_ON;
                units_d    = U_16;
                tick_cnt_d = '0;
              end
            end else if (!unit_end) begin
              tick_cnt_d = tick_cnt_q + 16'd1;
            end else if (units_q > U_1) begin
              tick_cnt_d = '0;
              units_d    = units_q - U_1;
            end else begin
              // segment finished: every new segment restarts the tick count
              tick_cnt_d = '0;
              units_d    = '0;
              case (phase_q)
                PH_PRE_ON1: begin
                  phase_d = PH_PRE_OFF;
                  units_d = U_2;
                end
                PH_PRE_OFF: begin
                  phase_d = PH_PRE_ON2;
                  units_d = U_2;
                end
                PH_PRE_ON2: begin
                  period_d = '0;
                  phase_d  = PH_GAP;
                  units_d  = U_2;
                end
                PH_GAP: begin
                  phase_d = PH_LEAD_ON;
                  units_d = U_16;
                end
                PH_LEAD_ON: begin
                  phase_d = PH_LEAD_OFF;
                  units_d = U_8;
                end
                PH_LEAD_OFF: begin
                  phase_d = PH_BIT_ON;
                  units_d = U_1;
                end
                PH_BIT_ON: begin
                  phase_d = PH_BIT_OFF;
                  units_d = shift_q[CODE_BITS-1] ? U_3 : U_1;
                end
                PH_BIT_OFF: begin
                  shift_d     = {shift_q[CODE_BITS-2:0], 1'b0};
                  bits_left_d = bits_left_q - BitsW'(1);
                  phase_d     = (bits_left_q != BitsW'(1)) ? PH_BIT_ON : PH_STOP_ON;
                  units_d     = U_1;
                end
                PH_RPT_ON: begin
                  phase_d = PH_RPT_OFF;
                  units_d = U_4;
                end
                PH_RPT_OFF: begin
                  phase_d = PH_RPT_END;
                  units_d = U_1;
                end
                PH_STOP_ON, PH_RPT_END: begin
                  if (!repeat_q) begin
                    phase_d = PH_IDLE;
                  end else if (per_inc >= frame_period_q) begin
                    // period already elapsed: repeat frame starts late
                    period_d = '0;
                    phase_d  = PH_RPT_ON;
                    units_d  = U_16;
                  end else begin
                    phase_d = PH_RPT_WAIT;
                  end
                end
                default: begin
                  phase_d = PH_IDLE;
                end
              endcase
            end
          end
        end
        OP_SEND: begin
          if (phase_q == PH_IDLE) begin
            shift_d     = in_i.code[CODE_BITS-1:0];
            bits_left_d = BITS_INIT;
            repeat_d    = in_i.repeat_wanted;
            period_d    = '0;
            phase_d     = PH_PRE_ON1;
            units_d     = U_2;
            tick_cnt_d  = '0;
          end
        end
        OP_STOP: begin
          repeat_d = 1'b0;
          if (phase_q == PH_RPT_WAIT) begin
            phase_d    = PH_IDLE;
            units_d    = '0;
            tick_cnt_d = '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign res_phase = (in_i.opcode == OP_TICK) ? phase_q : phase_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_ticks_q   <= UNIT_TICKS_RST;
      frame_period_q <= FRAME_PERIOD_RST;
      phase_q        <= PH_IDLE;
      shift_q        <= '0;
      bits_left_q    <= '0;
      tick_cnt_q     <= '0;
      units_q        <= '0;
      period_q       <= '0;
      repeat_q       <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_UNIT_TICKS) begin
          unit_ticks_q <= cfg_wdata_i[UnitW-1:0];
        end else if (cfg_idx_i == REG_FRAME_PERIOD) begin
          frame_period_q <= cfg_wdata_i[PeriodW-1:0];
        end
      end
      phase_q     <= phase_d;
      shift_q     <= shift_d;
      bits_left_q <= bits_left_d;
      tick_cnt_q  <= tick_cnt_d;
      units_q     <= units_d;
      period_q    <= period_d;
      repeat_q    <= repeat_d;
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, loaded with each accepted beat
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      carrier_q   <= carrier_of(res_phase);
      busy_q      <= (res_phase != PH_IDLE);
      repeating_q <= (res_phase >= PH_RPT_WAIT) && (res_phase <= PH_RPT_END);
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.carrier_on = carrier_q;
  assign out_o.busy_res   = busy_q;
  assign out_o.repeating  = repeating_q;

endmodule

### rtl/core/necirtx_checker.sv
// Port-level checker for the NEC IR transmitter, bound to the top level.
module necirtx_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic [1:0] in_opcode_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       carrier_on_i,
  input logic       busy_res_i,
  input logic       repeating_i
);
  import necirtx_pkg::*;

`include "nec_ir_frame_transmitter_assert.svh"

  logic send_beat;
  assign send_beat = in_valid_i && in_ready_i && (in_opcode_i == OP_SEND);

  // a stalled result beat is held
  `NECIRTX_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i)
  // every accepted command gives a result on the next edge
  `NECIRTX_ASSERT_NEXT(a_one_result, in_valid_i && in_ready_i, out_valid_i)
  // output register empty or draining means commands are taken
  `NECIRTX_ASSERT(a_no_bubble, (!out_valid_i || out_ready_i) |-> in_ready_i)
  // a send always leaves the block busy
  `NECIRTX_ASSERT_NEXT(a_send_busy, send_beat, busy_res_i)
  // carrier and repeat phase only inside a sequence
  `NECIRTX_ASSERT(a_idle_quiet,
                  out_valid_i |-> (busy_res_i || (!carrier_on_i && !repeating_i)))

endmodule

bind nec_ir_frame_transmitter necirtx_checker u_necirtx_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_opcode_i  (in_i.opcode),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .carrier_on_i (out_o.carrier_on),
  .busy_res_i   (out_o.busy_res),
  .repeating_i  (out_o.repeating)
);
